FILE: rtl/core/matrix_keypad_scan_debounce_core_macros.svh
// ---------------------------------------------------------------------------
// keypad scan core assertion macros
// shared assertion wrappers clocked on clk
// ---------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_CORE_MACROS_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_CORE_MACROS_SVH

// checked only outside reset
`define MKSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define MKSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/mksd_pkg.sv
// ---------------------------------------------------------------------------
// keypad scan package
// shared widths, reset value and lane control type
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mksd_pkg;

    localparam int THRESH_W = 8;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd8;
    localparam int CODE_W = 3;
    localparam int DRIVE_W = 3;
    localparam int RESULT_W = CODE_W + DRIVE_W;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic sample_we;
        logic level;
        logic debounce_en;
    } lane_ctl_t;

endpackage

FILE: rtl/core/mksd_lane.sv
// ---------------------------------------------------------------------------
// keypad scan debounce lane
// raw sample, integrating counter and stable bit of one key
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mksd_lane
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mksd_pkg::lane_ctl_t            ctl,
    input  logic [mksd_pkg::THRESH_W-1:0]  threshold,
    output logic                           stable_next
);

    logic                          raw_reg;
    logic                          raw_next;
    logic [mksd_pkg::THRESH_W-1:0] count_reg;
    logic [mksd_pkg::THRESH_W-1:0] count_next;
    logic                          stable_reg;

    always_comb
    begin
        raw_next    = ctl.sample_we ? ctl.level : raw_reg;
        count_next  = count_reg;
        stable_next = stable_reg;
        if (ctl.debounce_en)
        begin
            if (raw_next)
            begin
                if (count_reg < threshold)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    stable_next = 1'b1;
                end
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
            else
            begin
                stable_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b0;
            count_reg  <= '0;
            stable_reg <= 1'b0;
        end
        else
        begin
            raw_reg    <= raw_next;
            count_reg  <= count_next;
            stable_reg <= stable_next;
        end
    end

endmodule

FILE: rtl/core/mksd_merge.sv
// ---------------------------------------------------------------------------
// keypad scan merge
// priority pick of the first stable key, row-major, 1-based
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mksd_merge
#(
    parameter int NKEYS = 6
)
(
    input  logic [NKEYS-1:0]             stable,
    output logic [mksd_pkg::CODE_W-1:0]  key_code
);

    always_comb
    begin
        key_code = '0;
        for (int k = NKEYS - 1; k >= 0; k--)
        begin
            if (stable[k])
            begin
                key_code = mksd_pkg::CODE_W'(k + 1);
            end
        end
    end

endmodule

FILE: rtl/core/matrix_keypad_scan_debounce_core.sv
// ---------------------------------------------------------------------------
// keypad scan and debounce core
// one lane per key, priority merge, output register with skid stage
// ---------------------------------------------------------------------------
// the result of an accepted input transaction is registered into m_tdata, via the skid stage if the output stalls
// throughput: one transaction per cycle while s_tready is high; the lanes of the current row sample in parallel
// and all key lanes debounce in parallel on the last row. the skid stage keeps s_tready high for one stalled result
// reset clears the row pointer, samples, counters and stable bits
// and loads the press threshold with 8
`timescale 1ns / 1ps

`include "matrix_keypad_scan_debounce_core_macros.svh"

module matrix_keypad_scan_debounce_core
#(
    parameter int ROWS = 3,
    parameter int COLS = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mksd_pkg::THRESH_W-1:0]      cfg_wdata,   // press_threshold
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mksd_pkg::IN_DATA_W-1:0]     s_tdata,     // col0_level, col1_level
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mksd_pkg::OUT_DATA_W-1:0]    m_tdata      // key_code[2:0], row_drive[5:3]
);

    localparam int NKEYS = ROWS * COLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [mksd_pkg::THRESH_W-1:0] thresh_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [ROW_W-1:0]              row_next;
    logic                          accept;
    logic                          take_out;
    logic [NKEYS-1:0]              stable_next;
    logic [mksd_pkg::CODE_W-1:0]   key_code;
    logic [mksd_pkg::DRIVE_W-1:0]  row_drive;
    logic [mksd_pkg::RESULT_W-1:0] result;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mksd_pkg::RESULT_W-1:0] out_data_reg;
    logic [mksd_pkg::RESULT_W-1:0] out_data_next;
    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    logic [mksd_pkg::RESULT_W-1:0] skid_data_reg;
    logic [mksd_pkg::RESULT_W-1:0] skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take_out = out_valid_reg && m_tready;

    // key lanes
    for (genvar k = 0; k < NKEYS; k++)
    begin : g_lane
        localparam int R = k / COLS;
        localparam int C = k % COLS;
        mksd_pkg::lane_ctl_t ctl;
        logic                lvl;

        if (C < 2)
        begin : g_in
            assign lvl = s_tdata[C];
        end
        else
        begin : g_zero
            assign lvl = 1'b0;
        end

        assign ctl.sample_we   = accept && (row_reg == ROW_W'(R));
        assign ctl.level       = lvl;
        assign ctl.debounce_en = accept && (row_reg == LAST_ROW);

        mksd_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .threshold   (thresh_reg),
            .stable_next (stable_next[k])
        );
    end

    mksd_merge
    #(
        .NKEYS (NKEYS)
    )
    u_merge
    (
        .stable   (stable_next),
        .key_code (key_code)
    );

    // row advance and one-hot drive of the new row
    always_comb
    begin
        row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;
        for (int j = 0; j < mksd_pkg::DRIVE_W; j++)
        begin
            row_drive[j] = (j < ROWS) && (row_next == ROW_W'(j));
        end
    end

    assign result = {row_drive, key_code};

    // output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= mksd_pkg::THRESH_RESET;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            if (accept)
            begin
                row_reg <= row_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(mksd_pkg::OUT_DATA_W - mksd_pkg::RESULT_W)'(0), out_data_reg};

    `MKSD_ASSERT_ALWAYS(a_row_in_range, row_reg <= LAST_ROW, "row pointer beyond last row")
    `MKSD_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `MKSD_ASSERT(a_row_wrap, (accept && row_reg == LAST_ROW) |=> (row_reg == '0), "row did not wrap")
    `MKSD_ASSERT(a_drive_onehot, m_tvalid |-> $onehot0(m_tdata[5:3]), "row drive not one-hot")

endmodule
